[hw/rtl/spsm_pkg.sv]
// Shared constants, types and helper functions of the slotted page space manager.
package spsm_pkg;

  localparam int PAGE_BYTES       = 4096;
  localparam int HEADER_BYTES     = 21;
  localparam int SLOT_ENTRY_BYTES = 6;
  localparam int MAX_SLOTS        = 256;
  localparam int PREFIX_BYTES     = 2;

  localparam int ADDR_W = $clog2(MAX_SLOTS);
  localparam int CNT_W  = $clog2(MAX_SLOTS + 1);
  localparam int POS_W  = $clog2(PAGE_BYTES + 1);
  localparam int SUM_W  = POS_W + 1;
  localparam int LEN_W  = 12;
  localparam int SEQ_W  = 64;

  // opcodes
  localparam logic [2:0] OP_FORMAT  = 3'd0;
  localparam logic [2:0] OP_INSERT  = 3'd1;
  localparam logic [2:0] OP_REDO    = 3'd2;
  localparam logic [2:0] OP_READ    = 3'd3;
  localparam logic [2:0] OP_DELETE  = 3'd4;
  localparam logic [2:0] OP_UPDATE  = 3'd5;
  localparam logic [2:0] OP_COMPACT = 3'd6;
  localparam logic [2:0] OP_QUERY   = 3'd7;

  // status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NO_SPACE = 3'd1;
  localparam logic [2:0] ST_RANGE    = 3'd2;
  localparam logic [2:0] ST_DELETED  = 3'd3;
  localparam logic [2:0] ST_CORRUPT  = 3'd4;
  localparam logic [2:0] ST_SIZE     = 3'd5;

  typedef struct packed {
    logic             live;
    logic [POS_W-1:0] start;
    logic [LEN_W-1:0] len;
  } dir_entry_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    dir_entry_t        entry;
  } dir_wr_t;

  typedef struct packed {
    logic             all;
    logic             range_en;
    logic [CNT_W-1:0] lo;
    logic [CNT_W-1:0] hi;
  } dir_clr_t;

  function automatic logic [POS_W-1:0] dir_bottom(input logic [CNT_W-1:0] used);
    logic [31:0] dir;
    dir = 32'(used) * 32'(SLOT_ENTRY_BYTES);
    return (dir >= 32'(PAGE_BYTES)) ? '0 : POS_W'(32'(PAGE_BYTES) - dir);
  endfunction

  function automatic logic [POS_W-1:0] free_of(input logic [CNT_W-1:0] used,
                                               input logic [POS_W-1:0] front);
    logic [POS_W-1:0] top;
    top = dir_bottom(used);
    return (front <= top) ? top - front : '0;
  endfunction

  function automatic logic [POS_W-1:0] sat_page(input logic [SUM_W-1:0] v);
    return (v > SUM_W'(PAGE_BYTES)) ? POS_W'(PAGE_BYTES) : v[POS_W-1:0];
  endfunction

endpackage

[hw/rtl/spsm_dir.sv]
// Slot directory memory with per-entry valid bits; an invalid entry reads as zero.
module spsm_dir (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   rd_en_i,
  input  logic [spsm_pkg::ADDR_W-1:0] rd_addr_i,
  output spsm_pkg::dir_entry_t   rd_entry_o,
  input  spsm_pkg::dir_wr_t      wr_i,
  input  spsm_pkg::dir_clr_t     clr_i
);
  import spsm_pkg::*;

  dir_entry_t           mem [MAX_SLOTS];
  logic [MAX_SLOTS-1:0] vld_q;
  dir_entry_t           rdata_q;
  logic                 rvld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int i = 0; i < MAX_SLOTS; i++) begin
        if (clr_i.all) begin
          vld_q[i] <= 1'b0;
        end else if (wr_i.en && (wr_i.addr == ADDR_W'(i))) begin
          vld_q[i] <= 1'b1;
        end else if (clr_i.range_en && (CNT_W'(i) >= clr_i.lo) && (CNT_W'(i) < clr_i.hi)) begin
          vld_q[i] <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.entry;
    end
    if (rd_en_i) begin
      rdata_q <= mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rvld_q <= 1'b0;
    end else if (rd_en_i) begin
      rvld_q <= vld_q[rd_addr_i];
    end
  end

  assign rd_entry_o = rvld_q ? rdata_q : '0;

endmodule

[hw/rtl/slotted_page_space_manager_core.sv]
// Top level of the slotted page space manager: sequencer, page bookkeeping and result register.
// One transaction in, one transaction out. Format, query and out-of-range accesses go from
// S_START straight to S_FIN; read, delete, update and redo insert pass through S_ENT, since
// each reads its slot entry from the directory memory, whose single read port has a registered
// output. Insert passes through S_INS; when a tombstone is pending it first walks the directory
// in S_SCAN, one entry a cycle, until the lowest deleted slot is found (up to slots_used).
// Compact walks the directory in S_CMP one entry a cycle, reading the next entry while it
// rewrites the current one. All record-end sums go through one shared 14-bit adder. A new
// transaction is taken while the previous result still waits on the output register.
module slotted_page_space_manager_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [2:0]                    opcode_i,
  input  logic [7:0]                    slot_index_i,
  input  logic [11:0]                   record_length_i,
  input  logic [63:0]                   log_sequence_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [2:0]                    status_o,
  output logic [7:0]                    slot_result_o,
  output logic [12:0]                   record_start_o,
  output logic [11:0]                   length_result_o,
  output logic [12:0]                   free_bytes_o,
  output logic [63:0]                   page_sequence_o
);
  import spsm_pkg::*;

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_START = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_INS   = 3'd3;
  localparam logic [2:0] S_ENT   = 3'd4;
  localparam logic [2:0] S_CMP   = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;

  logic [2:0]        state_q, state_d;
  logic [2:0]        op_q;
  logic [7:0]        idx_q;
  logic [LEN_W-1:0]  len_q;
  logic [SEQ_W-1:0]  seq_q;

  logic [CNT_W-1:0]  used_q, used_d;
  logic [CNT_W-1:0]  tomb_q, tomb_d;
  logic [POS_W-1:0]  front_q, front_d;
  logic [SEQ_W-1:0]  hseq_q, hseq_d;

  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              found_q, found_d;
  logic [ADDR_W-1:0] pick_q, pick_d;
  logic [POS_W-1:0]  cfront_q, cfront_d;
  logic [CNT_W-1:0]  dead_q, dead_d;

  logic [2:0]        rst_q, rst_d;
  logic [7:0]        rslot_q, rslot_d;
  logic [POS_W-1:0]  rstart_q, rstart_d;
  logic [LEN_W-1:0]  rlen_q, rlen_d;

  logic              out_valid_q;
  logic [2:0]        status_q;
  logic [7:0]        slot_q;
  logic [POS_W-1:0]  start_q;
  logic [LEN_W-1:0]  length_q;
  logic [POS_W-1:0]  free_q;
  logic [SEQ_W-1:0]  pseq_q;

  logic              accept;
  logic              out_load;

  // directory port
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  dir_entry_t        ent;
  dir_wr_t           wr;
  dir_clr_t          clr;

  // shared record-end adder
  logic [POS_W-1:0]  add_base;
  logic [LEN_W-1:0]  add_len;
  logic [SUM_W-1:0]  add_sum;

  logic [CNT_W-1:0]  idx_ext;
  logic [CNT_W-1:0]  redo_used;
  logic [SUM_W-1:0]  need;
  logic [CNT_W-1:0]  cnt_inc;

  assign accept    = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign idx_ext   = {1'b0, idx_q};
  assign cnt_inc   = cnt_q + 1'b1;
  assign redo_used = (idx_ext >= used_q) ? idx_ext + 1'b1 : used_q;
  assign out_load  = (state_q == S_FIN) && (!out_valid_q || !out_stall_i);

  always_comb begin
    add_base = front_q;
    add_len  = len_q;
    if (state_q == S_CMP) begin
      add_base = cfront_q;
      add_len  = ent.len;
    end else if ((state_q == S_ENT) && (op_q == OP_READ)) begin
      add_base = ent.start;
      add_len  = ent.len;
    end
  end

  assign add_sum = SUM_W'(add_base) + SUM_W'(PREFIX_BYTES) + SUM_W'(add_len);
  assign need    = SUM_W'(PREFIX_BYTES) + SUM_W'(len_q) +
                   (found_q ? SUM_W'(0) : SUM_W'(SLOT_ENTRY_BYTES));

  spsm_dir u_dir (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (rd_en),
    .rd_addr_i  (rd_addr),
    .rd_entry_o (ent),
    .wr_i       (wr),
    .clr_i      (clr)
  );

  always_comb begin
    state_d  = state_q;
    used_d   = used_q;
    tomb_d   = tomb_q;
    front_d  = front_q;
    hseq_d   = hseq_q;
    cnt_d    = cnt_q;
    found_d  = found_q;
    pick_d   = pick_q;
    cfront_d = cfront_q;
    dead_d   = dead_q;
    rst_d    = rst_q;
    rslot_d  = rslot_q;
    rstart_d = rstart_q;
    rlen_d   = rlen_q;
    rd_en    = 1'b0;
    rd_addr  = cnt_inc[ADDR_W-1:0];
    wr       = '0;
    clr      = '0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_START;
        end
      end

      S_START: begin
        rst_d    = ST_OK;
        rslot_d  = '0;
        rstart_d = '0;
        rlen_d   = '0;
        cnt_d    = '0;
        case (op_q)
          OP_FORMAT: begin
            clr.all = 1'b1;
            used_d  = '0;
            tomb_d  = '0;
            front_d = sat_page(SUM_W'(HEADER_BYTES));
            hseq_d  = '0;
            state_d = S_FIN;
          end
          OP_INSERT: begin
            found_d = 1'b0;
            if ((tomb_q != '0) && (used_q != '0)) begin
              rd_en   = 1'b1;
              rd_addr = '0;
              state_d = S_SCAN;
            end else begin
              state_d = S_INS;
            end
          end
          OP_REDO: begin
            rslot_d = idx_q;
            if (idx_ext >= CNT_W'(MAX_SLOTS)) begin
              rst_d   = ST_RANGE;
              state_d = S_FIN;
            end else begin
              rd_en   = 1'b1;
              rd_addr = idx_q[ADDR_W-1:0];
              state_d = S_ENT;
            end
          end
          OP_READ, OP_DELETE, OP_UPDATE: begin
            rslot_d = idx_q;
            if ((idx_ext >= used_q) || (idx_ext >= CNT_W'(MAX_SLOTS))) begin
              rst_d   = ST_RANGE;
              state_d = S_FIN;
            end else begin
              rd_en   = 1'b1;
              rd_addr = idx_q[ADDR_W-1:0];
              state_d = S_ENT;
            end
          end
          OP_COMPACT: begin
            cfront_d = sat_page(SUM_W'(HEADER_BYTES));
            dead_d   = '0;
            if (used_q == '0) begin
              tomb_d   = '0;
              front_d  = sat_page(SUM_W'(HEADER_BYTES));
              rstart_d = sat_page(SUM_W'(HEADER_BYTES));
              state_d  = S_FIN;
            end else begin
              rd_en   = 1'b1;
              rd_addr = '0;
              state_d = S_CMP;
            end
          end
          default: begin
            rstart_d = front_q;
            state_d  = S_FIN;
          end
        endcase
      end

      // Walk the directory for the lowest deleted slot, one entry a cycle.
      S_SCAN: begin
        if (!ent.live) begin
          found_d = 1'b1;
          pick_d  = cnt_q[ADDR_W-1:0];
          state_d = S_INS;
        end else if (cnt_inc >= used_q) begin
          state_d = S_INS;
        end else begin
          rd_en = 1'b1;
          cnt_d = cnt_inc;
        end
      end

      S_INS: begin
        if ((!found_q && (used_q >= CNT_W'(MAX_SLOTS))) ||
            (SUM_W'(free_of(used_q, front_q)) < need)) begin
          rst_d = ST_NO_SPACE;
        end else begin
          wr.en          = 1'b1;
          wr.addr        = found_q ? pick_q : used_q[ADDR_W-1:0];
          wr.entry.live  = 1'b1;
          wr.entry.start = front_q;
          wr.entry.len   = len_q;
          if (found_q) begin
            tomb_d = tomb_q - 1'b1;
          end else begin
            used_d = used_q + 1'b1;
          end
          rslot_d  = 8'(wr.addr);
          rstart_d = front_q;
          rlen_d   = len_q;
          front_d  = sat_page(add_sum);
          if (seq_q > hseq_q) begin
            hseq_d = seq_q;
          end
        end
        state_d = S_FIN;
      end

      S_ENT: begin
        if (op_q == OP_REDO) begin
          rstart_d = front_q;
          rlen_d   = len_q;
          front_d  = sat_page(add_sum);
          if (idx_ext >= used_q) begin
            clr.range_en = 1'b1;
            clr.lo       = used_q;
            clr.hi       = idx_ext;
            used_d       = redo_used;
          end else if (!ent.live && (tomb_q != '0)) begin
            tomb_d = tomb_q - 1'b1;
          end
          wr.en          = 1'b1;
          wr.addr        = idx_q[ADDR_W-1:0];
          wr.entry.live  = 1'b1;
          wr.entry.start = front_q;
          wr.entry.len   = len_q;
          if (seq_q > hseq_q) begin
            hseq_d = seq_q;
          end
          if (add_sum > SUM_W'(dir_bottom(redo_used))) begin
            rst_d = ST_SIZE;
          end
        end else if (!ent.live) begin
          rst_d = ST_DELETED;
        end else begin
          rstart_d = ent.start;
          rlen_d   = ent.len;
          case (op_q)
            OP_READ: begin
              if ((ent.start < POS_W'(HEADER_BYTES)) || (add_sum > SUM_W'(PAGE_BYTES))) begin
                rst_d = ST_CORRUPT;
              end
            end
            OP_DELETE: begin
              wr.en   = 1'b1;
              wr.addr = idx_q[ADDR_W-1:0];
              if (tomb_q < CNT_W'(MAX_SLOTS)) begin
                tomb_d = tomb_q + 1'b1;
              end
              if (seq_q > hseq_q) begin
                hseq_d = seq_q;
              end
            end
            default: begin
              if (len_q != ent.len) begin
                rst_d = ST_SIZE;
              end else if (seq_q > hseq_q) begin
                hseq_d = seq_q;
              end
            end
          endcase
        end
        state_d = S_FIN;
      end

      // Rewrite entry cnt while the next one is read.
      S_CMP: begin
        wr.en   = 1'b1;
        wr.addr = cnt_q[ADDR_W-1:0];
        if (!ent.live) begin
          dead_d = dead_q + 1'b1;
        end else begin
          wr.entry.live  = 1'b1;
          wr.entry.start = cfront_q;
          wr.entry.len   = ent.len;
          cfront_d       = sat_page(add_sum);
        end
        if (cnt_inc >= used_q) begin
          tomb_d   = dead_d;
          front_d  = cfront_d;
          rstart_d = cfront_d;
          state_d  = S_FIN;
        end else begin
          rd_en = 1'b1;
          cnt_d = cnt_inc;
        end
      end

      S_FIN: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      used_q  <= '0;
      tomb_q  <= '0;
      front_q <= sat_page(SUM_W'(HEADER_BYTES));
      hseq_q  <= '0;
      cnt_q   <= '0;
      found_q <= 1'b0;
      dead_q  <= '0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
      tomb_q  <= tomb_d;
      front_q <= front_d;
      hseq_q  <= hseq_d;
      cnt_q   <= cnt_d;
      found_q <= found_d;
      dead_q  <= dead_d;
    end
  end

  // payload holds
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= opcode_i;
      idx_q <= slot_index_i;
      len_q <= record_length_i;
      seq_q <= log_sequence_i;
    end
    pick_q   <= pick_d;
    cfront_q <= cfront_d;
    rst_q    <= rst_d;
    rslot_q  <= rslot_d;
    rstart_q <= rstart_d;
    rlen_q   <= rlen_d;
  end

  // Result register: load on finish, drop valid once the transaction is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      status_q <= rst_q;
      slot_q   <= rslot_q;
      start_q  <= rstart_q;
      length_q <= rlen_q;
      free_q   <= free_of(used_q, front_q);
      pseq_q   <= hseq_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign slot_result_o   = slot_q;
  assign record_start_o  = start_q;
  assign length_result_o = length_q;
  assign free_bytes_o    = free_q;
  assign page_sequence_o = pseq_q;

  a_used_max : assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= CNT_W'(MAX_SLOTS)) else $error("slot count beyond directory size");

  a_tomb_le_used : assert property (@(posedge clk_i) disable iff (!rst_ni)
    tomb_q <= used_q) else $error("tombstone count exceeds used slots");

  a_front_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (front_q >= POS_W'(HEADER_BYTES)) && (front_q <= POS_W'(PAGE_BYTES)))
    else $error("data frontier out of page");

  a_out_from_fin : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_FIN)) else $error("result without finish");

endmodule
